// ===== rtl/fut_pkg.sv =====
// Package with the types, constants and decode functions of the form body tokenizer.
package fut_pkg;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_RESULTS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0] FIELD_LIMIT_RESET = 8'd32;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    KIND_KEY       = 3'd0,
    KIND_VALUE     = 3'd1,
    KIND_FIELD_END = 3'd2,
    KIND_ACCEPT    = 3'd3,
    KIND_REJECT    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_VALUE  = 2'd1,
    MODE_SKIP   = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_PERCENT = 2'd1,
    ESC_DIGIT   = 2'd2
  } esc_t;

  typedef struct packed {
    esc_t       esc;
    logic [7:0] held;
    mode_t      mode;
    logic       key_started;
    logic       part_cut;
    logic [7:0] fields_done;
    logic       zero_seen;
  } body_t;

  localparam body_t BODY_RESET = '{
    esc: ESC_NONE, held: 8'd0, mode: MODE_KEY, key_started: 1'b0,
    part_cut: 1'b0, fields_done: 8'd0, zero_seen: 1'b0
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } slot_t;

  typedef struct packed {
    slot_t [MAX_RESULTS-1:0] slot;
    logic [IDX_W-1:0]        last_idx;
  } bundle_t;

  typedef struct packed {
    body_t                   st;
    slot_t [MAX_RESULTS-1:0] slot;
    logic [CNT_W-1:0]        cnt;
  } work_t;

  // Returns the digit value, or 16 when the character is not a hex digit.
  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return v;
  endfunction

  function automatic work_t emit(work_t w_in, kind_t k, logic [7:0] ch);
    work_t w;
    w = w_in;
    if (w.cnt < CNT_W'(MAX_RESULTS)) begin
      w.slot[w.cnt[IDX_W-1:0]] = '{kind: k, ch: ch};
      w.cnt = w.cnt + CNT_W'(1);
    end
    return w;
  endfunction

  function automatic work_t put_byte(work_t w_in, logic [7:0] b, logic [7:0] limit);
    work_t w;
    w = w_in;
    unique case (w.st.mode)
      MODE_KEY: begin
        if (!w.st.part_cut) begin
          if (!w.st.key_started) begin
            if (b == 8'd0) begin
              w.st.mode = MODE_SKIP;
            end else if (w.st.fields_done >= limit) begin
              w.st.mode = MODE_IGNORE;
            end else begin
              w.st.key_started = 1'b1;
              if (w.st.fields_done != 8'hFF) begin
                w.st.fields_done = w.st.fields_done + 8'd1;
              end
              w = emit(w, KIND_KEY, b);
            end
          end else if (b == 8'd0) begin
            w.st.part_cut = 1'b1;
          end else begin
            w = emit(w, KIND_KEY, b);
          end
        end
      end
      MODE_VALUE: begin
        if (!w.st.part_cut) begin
          if (b == 8'd0) begin
            w.st.part_cut = 1'b1;
          end else begin
            w = emit(w, KIND_VALUE, b);
          end
        end
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic work_t take_char(work_t w_in, logic [7:0] c, logic [7:0] limit);
    work_t w;
    w = w_in;
    priority if (w.st.mode == MODE_IGNORE) begin
    end else if (c == CH_AMP) begin
      if (w.st.key_started) begin
        w = emit(w, KIND_FIELD_END, 8'd0);
      end
      w.st.mode = (w.st.fields_done >= limit) ? MODE_IGNORE : MODE_KEY;
      w.st.key_started = 1'b0;
      w.st.part_cut = 1'b0;
      w.st.esc = ESC_NONE;
    end else if (w.st.mode == MODE_KEY && c == CH_EQUAL) begin
      if (w.st.key_started) begin
        w.st.mode = MODE_VALUE;
        w.st.part_cut = 1'b0;
      end else begin
        w.st.mode = MODE_SKIP;
      end
    end else if (w.st.mode == MODE_SKIP || w.st.part_cut) begin
    end else if (c == CH_PLUS) begin
      w = put_byte(w, CH_SPACE, limit);
    end else if (c == CH_PERCENT) begin
      w.st.esc = ESC_PERCENT;
    end else begin
      w = put_byte(w, c, limit);
    end
    return w;
  endfunction

endpackage

// ===== rtl/fut_in_if.sv =====
// Channel interface for raw body characters.
interface fut_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_body;

  modport source(output valid, in_char, end_of_body, input ready);
  modport sink(input valid, in_char, end_of_body, output ready);
endinterface

// ===== rtl/fut_out_if.sv =====
// Channel interface for decoded result items.
interface fut_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source(output valid, result_kind, out_char, last_of_run, input ready);
  modport sink(input valid, result_kind, out_char, last_of_run, output ready);
endinterface

// ===== rtl/fut_front.sv =====
// Front end: accepts body characters, runs the decode state and builds result bundles.
module fut_front (
  input  logic             clk,
  input  logic             rst,
  fut_in_if.sink           body,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             push_ready,
  output logic             push_valid,
  output fut_pkg::bundle_t push_data
);
  import fut_pkg::*;

  body_t      st;
  body_t      st_next;
  logic [7:0] field_limit;
  work_t      w;
  logic       fire;
  logic [7:0] c;
  logic [4:0] hc;
  logic [4:0] hh;

  assign body.ready = push_ready;
  assign fire = body.valid && push_ready;
  assign c = body.in_char;
  assign hc = hex_of(c);
  assign hh = hex_of(st.held);

  always_comb begin
    w = '0;
    w.st = st;
    w.cnt = '0;
    if (c == 8'd0) begin
      w.st.zero_seen = 1'b1;
    end
    unique case (st.esc)
      ESC_PERCENT: begin
        if (!hc[4]) begin
          w.st.held = c;
          w.st.esc = ESC_DIGIT;
        end else begin
          w.st.esc = ESC_NONE;
          w = put_byte(w, CH_PERCENT, field_limit);
          w = take_char(w, c, field_limit);
        end
      end
      ESC_DIGIT: begin
        w.st.esc = ESC_NONE;
        if (!hc[4]) begin
          w = put_byte(w, {hh[3:0], hc[3:0]}, field_limit);
        end else begin
          w = put_byte(w, CH_PERCENT, field_limit);
          w = put_byte(w, st.held, field_limit);
          w = take_char(w, c, field_limit);
        end
      end
      default: begin
        w = take_char(w, c, field_limit);
      end
    endcase
    if (body.end_of_body) begin
      if (w.st.esc == ESC_PERCENT) begin
        w = put_byte(w, CH_PERCENT, field_limit);
      end else if (w.st.esc == ESC_DIGIT) begin
        w = put_byte(w, CH_PERCENT, field_limit);
        w = put_byte(w, w.st.held, field_limit);
      end
      w = emit(w, w.st.zero_seen ? KIND_REJECT : KIND_ACCEPT, 8'd0);
      w.st = BODY_RESET;
    end
    st_next = w.st;
  end

  assign push_valid = fire && (w.cnt != '0);
  assign push_data.slot = w.slot;
  assign push_data.last_idx = IDX_W'(w.cnt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BODY_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_limit <= FIELD_LIMIT_RESET;
    end else if (cfg_we) begin
      field_limit <= cfg_wdata;
    end
  end

  a_end_pushes: assert property (@(posedge clk) disable iff (rst)
    fire && body.end_of_body |-> push_valid)
    else $error("Body end did not produce a verdict.");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && body.end_of_body |=> st == BODY_RESET)
    else $error("Body state not cleared after its end.");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fire |-> w.cnt <= CNT_W'(MAX_RESULTS))
    else $error("Too many results for one item.");

endmodule

// ===== rtl/fut_queue.sv =====
// Short queue of result bundles between the front end and the output stage.
module fut_queue #(
  parameter int unsigned Depth = fut_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fut_pkg::bundle_t push_data,
  output logic             push_ready,
  output logic             head_valid,
  output fut_pkg::bundle_t head,
  input  logic             pop
);
  import fut_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t           mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign push_ready = count != CntW'(Depth);
  assign head_valid = count != '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("Push into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("Pop from an empty queue.");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("Queue count out of range.");

endmodule

// ===== rtl/fut_back.sv =====
// Output stage: sends the results of each bundle one item per cycle while token.ready is high.
module fut_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  fut_pkg::bundle_t head,
  output logic             pop,
  fut_out_if.source        token
);
  import fut_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             at_last;
  logic             fire;

  assign at_last = idx == head.last_idx;
  assign fire = head_valid && token.ready;
  assign pop = fire && at_last;

  assign token.valid = head_valid;
  assign token.result_kind = head.slot[idx].kind;
  assign token.out_char = head.slot[idx].ch;
  assign token.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= at_last ? '0 : idx + IDX_W'(1);
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.last_idx)
    else $error("Result index beyond its bundle.");
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    head_valid && !token.ready |=> $stable(idx))
    else $error("Result index moved while stalled.");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == '0)
    else $error("Result index not at start with no bundle waiting.");

endmodule

// ===== rtl/form_urlencoded_tokenizer.sv =====
// Top level of the form body tokenizer: front end, bundle queue and output stage.
//
//   Channel   Direction  Payload                                  Handshake
//   body      in         in_char[7:0], end_of_body                valid/ready
//   token     out        result_kind[2:0], out_char[7:0], last_of_run  valid/ready
//   cfg       in         cfg_wdata[7:0] (field_limit)             cfg_we
//
// One character is taken per cycle while the queue has room; its results are
// computed in the same cycle and stored as one bundle of up to four items.
// The output stage sends one item per cycle while token.ready is high;
// the queue absorbs bursts.
// Reset is synchronous and clears the body state; field_limit returns to 32.
// Body input stalls only when the queue is full.
module form_urlencoded_tokenizer #(
  parameter int unsigned QueueDepth = fut_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  fut_in_if.sink     body,
  fut_out_if.source  token,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import fut_pkg::*;

  logic    push;
  logic    push_ready;
  bundle_t push_data;
  logic    head_valid;
  bundle_t head;
  logic    pop;

  fut_front u_front (
    .clk       (clk),
    .rst       (rst),
    .body      (body),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push_ready(push_ready),
    .push_valid(push),
    .push_data (push_data)
  );

  fut_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .push_ready(push_ready),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  fut_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .token     (token)
  );

endmodule
